@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the soft switch memory mapper
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define SSMM_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ssmm assertion failed");

// consequent that must hold in the cycle after the antecedent
`define SSMM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssmm assertion failed");

`endif

@@ src/ssmm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmm_pkg
// Types and constants shared by the soft switch memory mapper modules
// ---------------------------------------------------------------------------
package ssmm_pkg;

  // result target codes
  typedef enum logic [2:0] {
    TGT_MAIN   = 3'd0,
    TGT_AUX    = 3'd1,
    TGT_ROM    = 3'd2,
    TGT_SROM   = 3'd3,
    TGT_SIO    = 3'd4,
    TGT_STATUS = 3'd5,
    TGT_FLOAT  = 3'd6,
    TGT_NONE   = 3'd7
  } target_t;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_PRESENT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_WITH_ROM = 2'd1;

  localparam int SlotMaskW = 7;

  // memory switch bit positions
  localparam int MSW_STORE80 = 0;
  localparam int MSW_RAMRD   = 1;
  localparam int MSW_RAMWRT  = 2;
  localparam int MSW_INTCX   = 3;
  localparam int MSW_ALTZP   = 4;
  localparam int MSW_SLOTC3  = 5;
  localparam int MSW_INTC8   = 6;

  // video switch bit positions
  localparam int VSW_COL80  = 0;
  localparam int VSW_ALTCHR = 1;
  localparam int VSW_TEXT   = 2;
  localparam int VSW_MIXED  = 3;
  localparam int VSW_PAGE2  = 4;
  localparam int VSW_HIRES  = 5;

  // address map constants
  localparam logic [15:0] ADDR_RESET_VEC = 16'hFFFC;
  localparam logic [15:0] ADDR_C8_OFF    = 16'hCFFF;
  localparam logic [15:0] ADDR_IO_BASE   = 16'hC000;
  localparam logic [15:0] ADDR_CX_BASE   = 16'hC100;
  localparam logic [15:0] ADDR_HIGH_BASE = 16'hD000;
  localparam logic [15:0] ADDR_ROM_HIGH  = 16'hE000;
  localparam logic [15:0] ADDR_EXP_BASE  = 16'hC800;
  localparam logic [15:0] ADDR_LC_BASE   = 16'hC080;
  localparam logic [15:0] ADDR_SIO_BASE  = 16'hC090;
  localparam logic [15:0] ADDR_ZP_END    = 16'h0200;
  localparam logic [15:0] ADDR_TXT1_END  = 16'h0400;
  localparam logic [15:0] ADDR_TXT2_END  = 16'h0800;
  localparam logic [15:0] ADDR_HGR_BASE  = 16'h2000;
  localparam logic [15:0] ADDR_HGR_END   = 16'h4000;
  localparam logic [15:0] BANK_OFS_MASK  = 16'h0FFF;
  localparam logic [15:0] BANK_ONE_BASE  = 16'hC000;
  localparam logic [15:0] BANK_TWO_BASE  = 16'hD000;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        side_effect;
    logic        vblank;
    logic        key_down;
  } req_t;

  typedef struct packed {
    target_t     target;
    logic [15:0] mem_addr;
    logic [2:0]  slot_number;
    logic [7:0]  data_out;
    logic        reset_taken;
  } rsp_t;

  // switch and banking state carried between the state register and decode
  typedef struct packed {
    logic [6:0] msw;
    logic       bank_one;
    logic       hram_rd;
    logic       hram_wr;
    logic [1:0] arm_cnt;
    logic [1:0] stack_cnt;
    logic [9:0] vsw;
  } mmu_state_t;

endpackage

@@ src/ssmm_decode.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmm_decode
// Single pass decode of one bus access: switch updates and target mapping
// ---------------------------------------------------------------------------
module ssmm_decode import ssmm_pkg::*; #(
  parameter int ROM_ADDR_BITS = 14
) (
  input  mmu_state_t           st,
  input  req_t                 req,
  input  logic [SlotMaskW-1:0] slots_present,
  input  logic [SlotMaskW-1:0] slots_with_rom,
  output mmu_state_t           st_next,
  output rsp_t                 rsp
);

  localparam logic [16:0] RomMaskW = (17'd1 << ROM_ADDR_BITS) - 17'd1;
  localparam logic [15:0] RomMask  = RomMaskW[15:0];

  // aux bank selection for main memory space
  function automatic logic is_aux(input logic [15:0] a, input logic sel,
                                  input logic [6:0] msw, input logic [9:0] vsw);
    logic r;
    if (a < ADDR_ZP_END) r = msw[MSW_ALTZP];
    else if (a < ADDR_TXT1_END) r = sel;
    else if (a < ADDR_TXT2_END) r = msw[MSW_STORE80] ? vsw[VSW_PAGE2] : sel;
    else if (a < ADDR_HGR_BASE) r = sel;
    else if (a < ADDR_HGR_END)
      r = (msw[MSW_STORE80] && vsw[VSW_HIRES]) ? vsw[VSW_PAGE2] : sel;
    else if (a >= ADDR_HIGH_BASE) r = msw[MSW_ALTZP];
    else r = sel;
    return r;
  endfunction

  logic        wr;
  logic        eff;
  logic        sel;
  logic        was_c8;
  logic        stat;
  logic [15:0] a;
  logic [2:0]  io_slot;
  logic [3:0]  cx_slot;
  mmu_state_t  s;

  always_comb begin
    s       = st;
    a       = req.addr;
    wr      = req.cmd;
    eff     = wr | req.side_effect;
    sel     = wr ? st.msw[MSW_RAMWRT] : st.msw[MSW_RAMRD];
    was_c8  = 1'b0;
    stat    = 1'b0;
    io_slot = a[6:4];
    cx_slot = a[11:8];
    rsp.target      = TGT_NONE;
    rsp.mem_addr    = a;
    rsp.slot_number = 3'd0;
    rsp.data_out    = req.data;
    rsp.reset_taken = 1'b0;

    // stack page run followed by reset vector fetch
    if (!wr && eff) begin
      if (a[15:8] == 8'h01) begin
        if (s.stack_cnt != 2'd3) s.stack_cnt = s.stack_cnt + 2'd1;
      end else begin
        if (s.stack_cnt == 2'd3 && a == ADDR_RESET_VEC) begin
          s.msw      = '0;
          s.bank_one = 1'b0;
          s.hram_rd  = 1'b0;
          s.hram_wr  = 1'b0;
          s.arm_cnt  = 2'd0;
          rsp.reset_taken = 1'b1;
          sel = 1'b0;
        end
        s.stack_cnt = 2'd0;
      end
    end

    if (a < ADDR_IO_BASE) begin
      // main memory space
      rsp.target = is_aux(a, sel, s.msw, s.vsw) ? TGT_AUX : TGT_MAIN;
    end else if (a < ADDR_CX_BASE) begin
      if (a >= ADDR_SIO_BASE) begin
        // slot i/o
        if (io_slot != 3'd0 && slots_present[io_slot - 3'd1]) begin
          rsp.target      = TGT_SIO;
          rsp.slot_number = io_slot;
        end else begin
          rsp.target = wr ? TGT_NONE : TGT_FLOAT;
        end
      end else begin
        // memory and video switch writes at c000-c00f
        if (a[15:4] == 12'hC00 && wr) begin
          if (a[3:1] < 3'd6) s.msw[a[3:1]] = a[0];
          else if (a[1]) s.vsw[VSW_ALTCHR] = a[0];
          else s.vsw[VSW_COL80] = a[0];
        end
        // video soft switches
        if (a[15:4] == 12'hC05 && eff) s.vsw[{1'b0, a[3:1]} + 4'd2] = a[0];
        // status reads
        if (a[15:4] == 12'hC01 && !wr) begin
          case (a[3:0])
            4'h0: stat = req.key_down;
            4'h1: stat = ~s.bank_one;
            4'h2: stat = s.hram_rd;
            4'h3: stat = s.msw[MSW_RAMRD];
            4'h4: stat = s.msw[MSW_RAMWRT];
            4'h5: stat = s.msw[MSW_INTCX];
            4'h6: stat = s.msw[MSW_ALTZP];
            4'h7: stat = s.msw[MSW_SLOTC3];
            4'h8: stat = s.msw[MSW_STORE80];
            4'h9: stat = ~req.vblank;
            4'hA: stat = s.vsw[VSW_TEXT];
            4'hB: stat = s.vsw[VSW_MIXED];
            4'hC: stat = s.vsw[VSW_PAGE2];
            4'hD: stat = s.vsw[VSW_HIRES];
            4'hE: stat = s.vsw[VSW_ALTCHR];
            default: stat = s.vsw[VSW_COL80];
          endcase
          rsp.target   = TGT_STATUS;
          rsp.data_out = {stat, 7'd0};
        end
        // language card bank and enable control
        if (a >= ADDR_LC_BASE && eff) begin
          s.bank_one = a[3];
          s.hram_rd  = (a[1:0] == 2'd0) || (a[1:0] == 2'd3);
          if (!a[0]) begin
            s.arm_cnt = 2'd0;
            s.hram_wr = 1'b0;
          end else if (!wr) begin
            if (s.arm_cnt < 2'd2) s.arm_cnt = s.arm_cnt + 2'd1;
            if (s.arm_cnt >= 2'd2) s.hram_wr = 1'b1;
          end else begin
            s.arm_cnt = 2'd0;
          end
        end
      end
    end else if (a < ADDR_HIGH_BASE) begin
      // peripheral rom space
      if (a[15:8] == 8'hC3 && eff && !s.msw[MSW_SLOTC3]) s.msw[MSW_INTC8] = 1'b1;
      was_c8 = s.msw[MSW_INTC8];
      if (eff && a == ADDR_C8_OFF) s.msw[MSW_INTC8] = 1'b0;
      if (!wr) begin
        if ((a >= ADDR_EXP_BASE && was_c8) || s.msw[MSW_INTCX] ||
            (!s.msw[MSW_SLOTC3] && a[15:8] == 8'hC3)) begin
          rsp.target   = TGT_ROM;
          rsp.mem_addr = a & RomMask;
        end else if (!cx_slot[3] && cx_slot[2:0] != 3'd0 &&
                     slots_present[cx_slot[2:0] - 3'd1] &&
                     slots_with_rom[cx_slot[2:0] - 3'd1]) begin
          rsp.target      = TGT_SROM;
          rsp.slot_number = cx_slot[2:0];
        end else begin
          rsp.target = TGT_FLOAT;
        end
      end
    end else if (wr) begin
      // high ram writes
      if (s.hram_wr) begin
        rsp.target = is_aux(a, sel, s.msw, s.vsw) ? TGT_AUX : TGT_MAIN;
        if (a < ADDR_ROM_HIGH)
          rsp.mem_addr = (a & BANK_OFS_MASK) | (s.bank_one ? BANK_ONE_BASE : BANK_TWO_BASE);
      end
    end else if (!s.hram_rd) begin
      rsp.target   = TGT_ROM;
      rsp.mem_addr = a & RomMask;
    end else begin
      // high ram reads
      rsp.target = is_aux(a, sel, s.msw, s.vsw) ? TGT_AUX : TGT_MAIN;
      if (a < ADDR_ROM_HIGH)
        rsp.mem_addr = (a & BANK_OFS_MASK) | (s.bank_one ? BANK_ONE_BASE : BANK_TWO_BASE);
    end

    st_next = s;
  end

endmodule

@@ src/soft_switch_memory_mapper.sv @@
// A request accepted at a clock edge shows its registered result from the next cycle.
// Throughput: one request per cycle while results are taken; the single result register is the only stage.
// The request side stays ready while the result register is empty or being taken.
// Reset clears all switches, counters, slot masks and the result valid flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// soft_switch_memory_mapper
// Soft switch memory mapper: bank state, language card and bus decode
// ---------------------------------------------------------------------------
module soft_switch_memory_mapper import ssmm_pkg::*; #(
  parameter int ROM_ADDR_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [SlotMaskW-1:0] cfg_data
);

  mmu_state_t           st;
  mmu_state_t           st_next;
  rsp_t                 rsp_next;
  logic [SlotMaskW-1:0] slots_present;
  logic [SlotMaskW-1:0] slots_with_rom;
  logic                 req_take;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_take  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // decode of the incoming request
  ssmm_decode #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS)
  ) u_decode (
    .st             (st),
    .req            (req),
    .slots_present  (slots_present),
    .slots_with_rom (slots_with_rom),
    .st_next        (st_next),
    .rsp            (rsp_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_present  <= '0;
      slots_with_rom <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOTS_PRESENT:  slots_present  <= cfg_data;
        CFG_SLOTS_WITH_ROM: slots_with_rom <= cfg_data;
        default: ;
      endcase
    end
  end

  // switch state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (req_take) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      rsp <= rsp_next;
    end
  end

  // a detected reset always fetches the vector from rom
  `SSMM_ASSERT(a_reset_to_rom, clk, rst,
    !(rsp_valid && rsp.reset_taken) || rsp.target == TGT_ROM)

  // detected reset leaves memory switches and language card cleared
  `SSMM_ASSERT_NEXT(a_reset_clears, clk, rst, req_take && rsp_next.reset_taken,
    st.msw == '0 && !st.hram_rd && !st.hram_wr && st.arm_cnt == 2'd0)

  // write arming count saturates at two
  `SSMM_ASSERT(a_arm_sat, clk, rst, st.arm_cnt != 2'd3)

  // status results carry only bit 7
  `SSMM_ASSERT(a_status_low_zero, clk, rst,
    !(rsp_valid && rsp.target == TGT_STATUS) || rsp.data_out[6:0] == 7'd0)

endmodule
